@@ src/spse_pkg.sv @@
package spse_pkg;

    // Highest power held in the coefficient store.
    localparam int MAX_DEGREE = 15;
    localparam int NUM_TERMS  = MAX_DEGREE + 1;
    localparam int PWR_W      = $clog2(NUM_TERMS);

    // Field widths of the stream payloads.
    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 8;
    localparam int Q_W      = 32;
    localparam int DEG_W    = 4;
    localparam int PROD_W   = 2 * Q_W;
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 40;

    // Operation codes carried in the action field.
    localparam logic [ACTION_W-1:0] ACT_SET  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_GET  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_EVAL = 2'd2;

    // Signed Q16.16 limits and the rounding constant for the product.
    localparam logic signed [PROD_W-1:0] Q_MAX  = PROD_W'(64'sd2147483647);
    localparam logic signed [PROD_W-1:0] Q_MIN  = -PROD_W'(64'sd2147483648);
    localparam logic signed [PROD_W-1:0] Q_HALF = PROD_W'(64'sd32768);

    typedef logic [NUM_TERMS-1:0] term_mask_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GET,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } spse_state_t;

    // Highest set bit of the term mask, or zero when the mask is empty.
    function automatic logic [PWR_W-1:0] highest_term(input term_mask_t mask);
        logic [PWR_W-1:0] deg;
        deg = '0;
        for (int i = 1; i < NUM_TERMS; i++) begin
            if (mask[i]) begin
                deg = PWR_W'(i);
            end
        end
        return deg;
    endfunction

endpackage

@@ src/sparse_polynomial_store_evaluator_core.sv @@
// Sparse polynomial store and evaluator, Q16.16 fixed point.
// Input channel s_*: one transaction carries an action (set, get or evaluate),
// a power index, a coefficient and an evaluation point x. Result channel m_*:
// exactly one transaction per input, with the value, the degree of the stored
// polynomial after the operation, a saturation flag and an index status.
// After acceptance, set and an unused action code go straight to the DONE state,
// an in-range get passes through the GET state for the registered memory read,
// and evaluate walks all 16 stored coefficients through one shared multiplier,
// each Horner step a MUL state (multiply) and then an ADD state (round, add and
// saturate); the DONE state then writes the result to the output register.
// One item is worked on at a time; the result sits in an output register, so
// the next item is accepted while an earlier result still waits on m_tready.
// A stalled receiver holds the block only when a second result is ready.
// Reset clears the term mask, so every power reads as zero (the empty
// polynomial) from the first cycle after reset; no clearing pass is needed.
module sparse_polynomial_store_evaluator_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // action[1:0], power_index[9:2], coefficient[41:10], x_value[73:42], zero pad
    input  logic [spse_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // result_value[31:0], poly_degree[35:32], overflow[36], status[37], zero pad
    output logic [spse_pkg::M_DATA_W-1:0] m_tdata
);
    import spse_pkg::*;

    // Input fields.
    logic [ACTION_W-1:0]   in_action;
    logic [INDEX_W-1:0]    in_power;
    logic signed [Q_W-1:0] in_coef;
    logic signed [Q_W-1:0] in_x;
    logic                  in_range_ok;
    logic                  s_accept;

    assign in_action   = s_tdata[1:0];
    assign in_power    = s_tdata[9:2];
    assign in_coef     = s_tdata[41:10];
    assign in_x        = s_tdata[73:42];
    assign in_range_ok = (in_power <= INDEX_W'(MAX_DEGREE));

    // Control and datapath registers.
    spse_state_t             state_reg, state_next;
    term_mask_t              mask_reg, mask_next;
    logic [PWR_W-1:0]        pwr_reg, pwr_next;
    logic signed [Q_W-1:0]   x_reg, x_next;
    logic signed [Q_W-1:0]   acc_reg, acc_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] mul_full;
    logic                    sat_reg, sat_next;
    logic                    status_reg, status_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]     m_tdata_reg, m_tdata_next;

    // Coefficient memory: one write port, one registered read port.
    logic signed [Q_W-1:0]   coef_mem [NUM_TERMS];
    logic                    mem_we;
    logic [PWR_W-1:0]        mem_waddr;
    logic [PWR_W-1:0]        mem_raddr;
    logic signed [Q_W-1:0]   rd_data_reg;
    logic                    rd_valid_reg;
    logic signed [Q_W-1:0]   rd_coef;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            coef_mem[mem_waddr] <= in_coef;
        end
        rd_data_reg  <= coef_mem[mem_raddr];
        rd_valid_reg <= mask_reg[mem_raddr];
    end

    // A power whose mask bit is clear reads as zero, which also covers reset.
    assign rd_coef = rd_valid_reg ? rd_data_reg : '0;

    // The block takes a new transaction only while idle.
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign mem_waddr = in_power[PWR_W-1:0];
    assign mem_raddr = (state_reg == ST_IDLE) ? in_power[PWR_W-1:0] : pwr_reg;

    // Horner multiply, registered before the rounding and accumulation.
    assign mul_full = acc_reg * x_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= mul_full;
    end

    // Round half up, drop the fraction, saturate, add the term, saturate.
    logic signed [PROD_W-1:0] shr_val;
    logic signed [Q_W-1:0]    scaled;
    logic                     scaled_sat;
    logic signed [Q_W:0]      sum_val;
    logic signed [Q_W-1:0]    step_val;
    logic                     step_sat;

    always_comb begin
        shr_val    = (prod_reg + Q_HALF) >>> 16;
        scaled_sat = 1'b0;
        if (shr_val > Q_MAX) begin
            scaled     = Q_MAX[Q_W-1:0];
            scaled_sat = 1'b1;
        end else if (shr_val < Q_MIN) begin
            scaled     = Q_MIN[Q_W-1:0];
            scaled_sat = 1'b1;
        end else begin
            scaled = shr_val[Q_W-1:0];
        end

        sum_val  = {scaled[Q_W-1], scaled} + {rd_coef[Q_W-1], rd_coef};
        step_sat = 1'b0;
        if (sum_val[Q_W] != sum_val[Q_W-1]) begin
            step_sat = 1'b1;
            step_val = sum_val[Q_W] ? Q_MIN[Q_W-1:0] : Q_MAX[Q_W-1:0];
        end else begin
            step_val = sum_val[Q_W-1:0];
        end
    end

    // State and payload registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mask_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mask_reg     <= mask_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        pwr_reg     <= pwr_next;
        x_reg       <= x_next;
        acc_reg     <= acc_next;
        sat_reg     <= sat_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Sequencer: decode, memory access, Horner walk, result hand-off.
    always_comb begin
        state_next    = state_reg;
        mask_next     = mask_reg;
        pwr_next      = pwr_reg;
        x_next        = x_reg;
        acc_next      = acc_reg;
        sat_next      = sat_reg;
        status_next   = status_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        mem_we        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    acc_next    = '0;
                    sat_next    = 1'b0;
                    status_next = 1'b0;
                    state_next  = ST_DONE;
                    case (in_action)
                        ACT_SET: begin
                            status_next = !in_range_ok;
                            if (in_range_ok) begin
                                mem_we = 1'b1;
                                mask_next[in_power[PWR_W-1:0]] = (in_coef != '0);
                            end
                        end
                        ACT_GET: begin
                            status_next = !in_range_ok;
                            if (in_range_ok) begin
                                state_next = ST_GET;
                            end
                        end
                        ACT_EVAL: begin
                            x_next     = in_x;
                            pwr_next   = PWR_W'(MAX_DEGREE);
                            state_next = ST_MUL;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_GET: begin
                acc_next   = rd_coef;
                state_next = ST_DONE;
            end
            ST_MUL: begin
                state_next = ST_ADD;
            end
            ST_ADD: begin
                acc_next = step_val;
                sat_next = sat_reg || scaled_sat || step_sat;
                if (pwr_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    pwr_next   = pwr_reg - 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, status_reg, sat_reg,
                                     DEG_W'(highest_term(mask_reg)), acc_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ verif/tb_sparse_polynomial_store_evaluator_core.sv @@
module tb_sparse_polynomial_store_evaluator_core;

    timeunit 1ns;
    timeprecision 1ps;

    import spse_pkg::*;

    // The action code that the block leaves unused.
    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

    localparam int RANDOM_ITEMS = 1250;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;

    // Input transaction, packed from the lowest bit up as on s_tdata.
    typedef struct packed {
        logic [Q_W-1:0]      x_value;
        logic [Q_W-1:0]      coefficient;
        logic [INDEX_W-1:0]  power;
        logic [ACTION_W-1:0] action;
    } poly_op_t;

    // Result transaction, packed from the lowest bit up as on m_tdata.
    typedef struct packed {
        logic             status;
        logic             overflow;
        logic [DEG_W-1:0] degree;
        logic [Q_W-1:0]   value;
    } poly_result_t;

    typedef struct {
        poly_op_t     op;
        bit           typed;
        poly_result_t want;
    } op_row_t;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // Predictor state: the stored coefficients and the mask of nonzero terms.
    logic [Q_W-1:0]   coef_mem [NUM_TERMS];
    logic [NUM_TERMS-1:0] term_mask;

    poly_result_t expected_results [$];
    op_row_t      directed_ops [$];
    int           error_count   = 0;
    int           results_seen  = 0;
    int           cycle_count   = 0;
    bit           quiet         = 1'b0;

    sparse_polynomial_store_evaluator_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Clamp to the signed 32-bit range and note any clamping.
    function automatic longint clamp_q32(input longint v, inout bit clamped);
        if (v > 64'sd2147483647) begin
            clamped = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            clamped = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Applies one operation to the predictor state and returns its result.
    function automatic poly_result_t poly_apply(input poly_op_t op);
        poly_result_t r;
        longint       acc;
        longint       prod;
        bit           clamped;
        r       = '0;
        clamped = 1'b0;
        if (op.action == ACT_SET || op.action == ACT_GET) begin
            if (op.power > MAX_DEGREE) begin
                r.status = 1'b1;
            end else if (op.action == ACT_SET) begin
                coef_mem[op.power[PWR_W-1:0]]  = op.coefficient;
                term_mask[op.power[PWR_W-1:0]] = (op.coefficient != '0);
            end else begin
                r.value = coef_mem[op.power[PWR_W-1:0]];
            end
        end else if (op.action == ACT_EVAL) begin
            // Horner walk from the top power down, rounding half up each step.
            acc = 0;
            for (int p = MAX_DEGREE; p >= 0; p--) begin
                prod = acc * longint'($signed(op.x_value));
                acc  = clamp_q32((prod + 64'sd32768) >>> 16, clamped);
                acc  = clamp_q32(acc + longint'($signed(coef_mem[p])), clamped);
            end
            r.value    = acc[Q_W-1:0];
            r.overflow = clamped;
        end
        for (int i = 1; i < NUM_TERMS; i++) begin
            if (term_mask[i]) begin
                r.degree = DEG_W'(i);
            end
        end
        return r;
    endfunction

    function automatic poly_result_t res(input int st, input int ov, input int dg,
                                         input logic [Q_W-1:0] v);
        poly_result_t r;
        r.status   = (st != 0);
        r.overflow = (ov != 0);
        r.degree   = DEG_W'(dg);
        r.value    = v;
        return r;
    endfunction

    function automatic op_row_t row(input logic [ACTION_W-1:0] act, input int pw,
                                    input logic [Q_W-1:0] c, input logic [Q_W-1:0] x,
                                    input int typed, input poly_result_t want);
        op_row_t t;
        t.op.action      = act;
        t.op.power       = INDEX_W'(pw);
        t.op.coefficient = c;
        t.op.x_value     = x;
        t.typed          = (typed != 0);
        t.want           = want;
        return t;
    endfunction

    // Random Q16.16 value: mostly small magnitudes, with extremes and noise mixed in.
    function automatic logic [Q_W-1:0] pick_q32(input int lim);
        int v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0001;
                endcase
            end
            1, 2: v = $urandom;
            3: v = 0;
            default: v = int'($urandom_range(0, 2 * lim)) - lim;
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [Q_W-1:0] want,
                                   input logic [Q_W-1:0] got);
        $display("[%0t] result %0d %s mismatch: expected %h, got %h",
                 $time, results_seen, what, want, got);
        error_count++;
    endtask

    // Drives one input transaction and records its expected result on acceptance.
    task automatic push_op(input poly_op_t op, input bit typed, input poly_result_t want);
        int           gap;
        poly_result_t model;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - $bits(poly_op_t)){1'b0}}, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        model = poly_apply(op);
        expected_results.push_back(typed ? want : model);
    endtask

    // Receiver side: random stalls in bursts, no new burst starting while the run is quiet.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 19);
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare each result transaction against the oldest expectation.
    always @(posedge aclk) begin
        poly_result_t got;
        poly_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = poly_result_t'(m_tdata[$bits(poly_result_t)-1:0]);
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transaction", '0, got.value);
            end else begin
                want = expected_results.pop_front();
                if (got.value !== want.value) begin
                    report_mismatch("result_value", want.value, got.value);
                end
                if (got.degree !== want.degree) begin
                    report_mismatch("poly_degree", want.degree, got.degree);
                end
                if (got.overflow !== want.overflow) begin
                    report_mismatch("overflow", want.overflow, got.overflow);
                end
                if (got.status !== want.status) begin
                    report_mismatch("status", want.status, got.status);
                end
            end
            results_seen++;
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Main sequence: reset, directed table, random traffic, drain.
    initial begin
        poly_op_t op;
        int       r;

        for (int i = 0; i < NUM_TERMS; i++) begin
            coef_mem[i] = '0;
        end
        term_mask = '0;

        // Directed table; typed expectations only where the answer is obvious.
        directed_ops.push_back(row(ACT_GET,  0,   32'h0,         32'h0,         1, res(0, 0, 0, 32'h0)));
        directed_ops.push_back(row(ACT_EVAL, 0,   32'h0,         32'h7FFF_FFFF, 1, res(0, 0, 0, 32'h0)));
        directed_ops.push_back(row(ACT_GET,  255, 32'h0,         32'h0,         1, res(1, 0, 0, 32'h0)));
        directed_ops.push_back(row(ACT_SET,  16,  32'h5,         32'h0,         1, res(1, 0, 0, 32'h0)));
        directed_ops.push_back(row(ACT_NONE, 255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, res(0, 0, 0, 32'h0)));
        directed_ops.push_back(row(ACT_SET,  0,   32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, res(0, 0, 0, 32'h0)));
        directed_ops.push_back(row(ACT_SET,  15,  32'h8000_0000, 32'h0,         1, res(0, 0, 15, 32'h0)));
        directed_ops.push_back(row(ACT_GET,  15,  32'h0,         32'h0,         1,
                                   res(0, 0, 15, 32'h8000_0000)));
        directed_ops.push_back(row(ACT_GET,  0,   32'h0,         32'h0,         1,
                                   res(0, 0, 15, 32'h7FFF_FFFF)));
        directed_ops.push_back(row(ACT_EVAL, 0,   32'h0,         32'h0,         0, '0));
        directed_ops.push_back(row(ACT_EVAL, 255, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, '0));
        directed_ops.push_back(row(ACT_EVAL, 0,   32'h0,         32'h8000_0000, 0, '0));
        directed_ops.push_back(row(ACT_SET,  15,  32'h0,         32'h0,         1, res(0, 0, 0, 32'h0)));
        directed_ops.push_back(row(ACT_GET,  15,  32'h0,         32'h0,         1, res(0, 0, 0, 32'h0)));
        directed_ops.push_back(row(ACT_SET,  1,   32'h0001_0000, 32'h0,         0, '0));
        directed_ops.push_back(row(ACT_SET,  0,   32'h0001_0000, 32'h0,         0, '0));
        directed_ops.push_back(row(ACT_EVAL, 0,   32'h0,         32'h0001_0000, 0, '0));
        directed_ops.push_back(row(ACT_EVAL, 0,   32'h0,         32'hFFFF_0000, 0, '0));
        directed_ops.push_back(row(ACT_SET,  7,   32'hFFFF_FFFF, 32'h0,         0, '0));
        directed_ops.push_back(row(ACT_EVAL, 0,   32'h0,         32'h0000_8000, 0, '0));
        directed_ops.push_back(row(ACT_EVAL, 0,   32'h0,         32'hFFFF_8000, 0, '0));
        directed_ops.push_back(row(ACT_SET,  15,  32'h7FFF_FFFF, 32'h0,         0, '0));
        directed_ops.push_back(row(ACT_GET,  16,  32'h0,         32'h1234_5678, 1,
                                   res(1, 0, 15, 32'h0)));
        directed_ops.push_back(row(ACT_NONE, 3,   32'h1,         32'h0001_8000, 0, '0));
        directed_ops.push_back(row(ACT_SET,  0,   32'h0,         32'h0,         0, '0));

        // Synchronous reset, released at a falling clock edge.
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_ops[i]) begin
            push_op(directed_ops[i].op, directed_ops[i].typed, directed_ops[i].want);
        end

        // Random traffic with a quiet stretch mid-run and a quiet tail.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet = (n >= 500 && n < 650) || (n >= RANDOM_ITEMS - 150);
            r = $urandom_range(0, 19);
            if (r == 0) begin
                op.action = ACT_NONE;
            end else if (r <= 7) begin
                op.action = ACT_SET;
            end else if (r <= 12) begin
                op.action = ACT_GET;
            end else begin
                op.action = ACT_EVAL;
            end
            op.power       = ($urandom_range(0, 9) == 0) ? INDEX_W'($urandom_range(16, 255))
                                                         : INDEX_W'($urandom_range(0, 15));
            op.coefficient = pick_q32(32'h0004_0000);
            op.x_value     = pick_q32(32'h0001_8000);
            push_op(op, 1'b0, '0);
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        // Drain outstanding results, then allow for any stray late output.
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
